### rtl/pss_pkg.sv
// Package for the polyline smoothing and simplification block.
// Types, field widths, register indexes and state encodings; no dependencies.
package pss_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MIN_POLY       = 3;

  localparam int COORD_W = 32;
  localparam int THK_W   = 16;
  localparam int PASS_W  = 4;
  localparam int THR_W   = 18;
  localparam int UNIT_W  = 18;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_PASSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THK_PASSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_THR   = 2'd2;

  localparam logic [PASS_W-1:0] POS_PASSES_RST = 4'd1;
  localparam logic [PASS_W-1:0] THK_PASSES_RST = 4'd0;
  localparam logic [THR_W-1:0]  BEND_THR_RST   = 18'd0;

  localparam int BEND_ONE = 65536;
  localparam int BEND_MAX = 131072;

  // unit direction arithmetic
  localparam int NORM_BIT = 19;             // largest magnitude lands in [2^19, 2^20)
  localparam int MAG_W    = NORM_BIT + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = 18;
  localparam int NUM_W    = MAG_W + FRAC_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [THK_W-1:0]          width_in;
    logic                      end_of_stroke;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [THK_W-1:0]          width_out;
    logic                      final_point;
    logic                      overflowed;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [THK_W-1:0]          w;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BEGIN,
    S_SM_START,
    S_SM_CAP0,
    S_SM_CAP1,
    S_SM_RDN,
    S_SM_CAPN,
    S_SM_DIV,
    S_SM_WR,
    S_CP_START,
    S_CP_CAPA,
    S_CP_NEXT,
    S_CP_CAPB,
    S_CP_UD,
    S_CP_MUL,
    S_CP_SUM,
    S_CP_CMP,
    S_CP_ADV,
    S_EM_NEXT,
    S_EM_OUT
  } state_t;

  typedef enum logic [2:0] {
    UD_IDLE,
    UD_NORM,
    UD_SQ,
    UD_SUM,
    UD_SQRT,
    UD_DIVI,
    UD_DIV,
    UD_FIN
  } ud_state_t;

endpackage

### rtl/pss_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pss_div3.sv
// Three-lane divide by three with rounding to nearest, four quotient bits a cycle.
// Depends on pss_pkg.
module pss_div3
  import pss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W+1:0] sum [3],
  output logic                      done,
  output logic signed [COORD_W-1:0] q [3]
);

  localparam int DIG   = 4;
  localparam int DW    = 36;
  localparam int STEPS = DW / DIG;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [2:0] THREE = 3'd3;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    mag [3];
  logic [DW-1:0]    quo [3];
  logic [1:0]       rem [3];
  logic             neg [3];
  logic [DW-1:0]    mag_next [3];
  logic [DW-1:0]    quo_next [3];
  logic [1:0]       rem_next [3];
  logic signed [COORD_W+1:0] s_abs [3];

  always_comb begin
    logic [2:0]    t;
    logic [1:0]    r;
    logic [DW-1:0] m;
    logic [DW-1:0] qq;
    for (int k = 0; k < 3; k++) begin
      s_abs[k] = sum[k][COORD_W+1] ? -sum[k] : sum[k];
      r  = rem[k];
      m  = mag[k];
      qq = quo[k];
      for (int j = 0; j < DIG; j++) begin
        t  = {r, m[DW-1]};
        m  = m << 1;
        qq = {qq[DW-2:0], t >= THREE};
        if (t >= THREE) begin
          t = t - THREE;
        end
        r = t[1:0];
      end
      mag_next[k] = m;
      quo_next[k] = qq;
      rem_next[k] = r;
      q[k] = neg[k] ? -$signed(quo[k][COORD_W-1:0]) : $signed(quo[k][COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        mag[k] <= DW'($unsigned(s_abs[k])) + DW'(1);
        neg[k] <= sum[k][COORD_W+1];
        quo[k] <= '0;
        rem[k] <= '0;
      end else if (busy) begin
        mag[k] <= mag_next[k];
        quo[k] <= quo_next[k];
        rem[k] <= rem_next[k];
      end
    end
  end

endmodule

### rtl/pss_udir.sv
// Unit direction of one segment: normalize, sum of squares, square root, divide.
// Depends on pss_pkg.
module pss_udir
  import pss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COORD_W:0]  diff [3],
  output logic                     done,
  output logic signed [UNIT_W-1:0] u [3]
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  ud_state_t state, state_next;

  logic [COORD_W-1:0] m [3];
  logic               neg [3];
  logic [SQ_W-1:0]    sq [3];
  logic [SUM_W-1:0]   rad;
  logic [ROOT_W+1:0]  srem;
  logic [ROOT_W-1:0]  root;
  logic [CNT_W-1:0]   cnt;
  logic [QUO_W-1:0]   num [3];
  logic [ROOT_W-1:0]  drem [3];
  logic [QUO_W-1:0]   quo [3];

  logic [COORD_W-1:0] mx;
  logic [ROOT_W+3:0]  srem2;
  logic [ROOT_W+3:0]  trial;
  logic               sq_ge;
  logic [ROOT_W:0]    dt [3];
  logic               dge [3];
  logic [NUM_W-1:0]   numv [3];
  logic signed [COORD_W:0] dabs [3];

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    srem2 = {srem, rad[SUM_W-1:SUM_W-2]};
    trial = (ROOT_W+4)'({root, 2'b01});
    sq_ge = srem2 >= trial;
    for (int k = 0; k < 3; k++) begin
      dabs[k] = diff[k][COORD_W] ? -diff[k] : diff[k];
      dt[k]   = {drem[k], num[k][QUO_W-1]};
      dge[k]  = dt[k] >= {1'b0, root};
      numv[k] = {1'b0, m[k][MAG_W-1:0], {FRAC_W{1'b0}}} + NUM_W'(root >> 1);
      u[k]    = neg[k] ? -$signed(quo[k]) : $signed(quo[k]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      UD_IDLE: begin
        if (start) state_next = UD_NORM;
      end
      UD_NORM: begin
        if (mx == '0) begin
          state_next = UD_FIN;
        end else if (mx[COORD_W-1:MAG_W] == '0 && mx[NORM_BIT]) begin
          state_next = UD_SQ;
        end
      end
      UD_SQ:   state_next = UD_SUM;
      UD_SUM:  state_next = UD_SQRT;
      UD_SQRT: begin
        if (cnt == CNT_W'(ROOT_W - 1)) state_next = UD_DIVI;
      end
      UD_DIVI: state_next = UD_DIV;
      UD_DIV: begin
        if (cnt == CNT_W'(QUO_W - 1)) state_next = UD_FIN;
      end
      UD_FIN:  state_next = UD_IDLE;
      default: state_next = UD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == UD_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= UD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      UD_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          m[k]   <= COORD_W'($unsigned(dabs[k]));
          neg[k] <= diff[k][COORD_W];
        end
      end
      UD_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (mx == '0) begin
            quo[k] <= '0;
          end else if (mx[COORD_W-1:MAG_W] != '0) begin
            m[k] <= m[k] >> 1;
          end else if (!mx[NORM_BIT]) begin
            m[k] <= m[k] << 1;
          end
        end
      end
      UD_SQ: begin
        for (int k = 0; k < 3; k++) begin
          sq[k] <= m[k][MAG_W-1:0] * m[k][MAG_W-1:0];
        end
      end
      UD_SUM: begin
        rad  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        srem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      UD_SQRT: begin
        rad  <= rad << 2;
        cnt  <= cnt + 1'b1;
        root <= {root[ROOT_W-2:0], sq_ge};
        srem <= sq_ge ? (ROOT_W+2)'(srem2 - trial) : (ROOT_W+2)'(srem2);
      end
      UD_DIVI: begin
        cnt <= '0;
        for (int k = 0; k < 3; k++) begin
          drem[k] <= ROOT_W'(numv[k][NUM_W-1:QUO_W]);
          num[k]  <= numv[k][QUO_W-1:0];
          quo[k]  <= '0;
        end
      end
      UD_DIV: begin
        cnt <= cnt + 1'b1;
        for (int k = 0; k < 3; k++) begin
          num[k]  <= num[k] << 1;
          quo[k]  <= {quo[k][QUO_W-2:0], dge[k]};
          drem[k] <= dge[k] ? ROOT_W'(dt[k] - {1'b0, root}) : dt[k][ROOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/polyline_smooth_and_simplify.sv
// Polyline smoothing and simplification, top level. Depends on pss_pkg, pss_ram, pss_div3, pss_udir.
// Loading: one point per cycle; the end mark stalls input until the last point is emitted.
// Smoothing: each pass reads the first two points, then per interior point reads the next and writes
// back the mean (positions via pss_div3). Compression: one scan per removed point plus one;
// unit directions by pss_udir (normalize, square root, divide). Emission: one result per kept point.
// Synchronous active-high reset clears stroke state and loads register defaults.
module polyline_smooth_and_simplify
  import pss_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_t                point,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * UNIT_W;
  localparam int DW = PW + 2;

  state_t state, state_next;

  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  ovf;
  logic [PASS_W-1:0]     pos_passes;
  logic [PASS_W-1:0]     thk_passes;
  logic [THR_W-1:0]      bend_thr;
  logic [PASS_W-1:0]     pass_left;
  logic                  thk_phase;
  logic [MAX_POINTS-1:0] mask;
  logic                  found;
  logic                  have_u;
  logic [THR_W-1:0]      minb;
  logic [AW-1:0]         best;
  logic [AW-1:0]         prev_idx;

  entry_t prev, cur, nxt, rdata, wdata;
  entry_t pa, pb;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic signed [UNIT_W-1:0] u_prev [3];
  logic signed [UNIT_W-1:0] u_cur [3];
  logic signed [UNIT_W-1:0] ud_u [3];
  logic signed [PW-1:0]     prod [3];
  logic signed [DW-1:0]     dot;
  logic signed [DW-1:0]     tq;
  logic signed [DW-1:0]     bv;
  logic [THR_W-1:0]         bend;

  logic                      ud_start, ud_done;
  logic signed [COORD_W:0]   ud_diff [3];
  logic                      d3_start, d3_done;
  logic signed [COORD_W+1:0] d3_sum [3];
  logic signed [COORD_W-1:0] d3_q [3];

  logic             accept;
  logic             room;
  logic             out_free;
  logic             last_step;
  logic             scan_end;
  logic             cur_removed;
  logic [THK_W:0]   wsum;

  assign accept      = point_valid && !point_stall;
  assign room        = count < CW'(MAX_POINTS);
  assign out_free    = !result_valid || !result_stall;
  assign last_step   = idx == count - CW'(2);
  assign scan_end    = idx == count;
  assign cur_removed = mask[idx[AW-1:0]];
  assign point_stall = state != S_IDLE;
  assign cfg_ready   = 1'b1;
  assign wsum        = {1'b0, prev.w} + {1'b0, nxt.w} + (THK_W+1)'(1);

  always_comb begin
    d3_sum[0]  = (COORD_W+2)'(prev.x) + (COORD_W+2)'(cur.x) + (COORD_W+2)'(rdata.x);
    d3_sum[1]  = (COORD_W+2)'(prev.y) + (COORD_W+2)'(cur.y) + (COORD_W+2)'(rdata.y);
    d3_sum[2]  = (COORD_W+2)'(prev.z) + (COORD_W+2)'(cur.z) + (COORD_W+2)'(rdata.z);
    ud_diff[0] = (COORD_W+1)'(rdata.x) - (COORD_W+1)'(pa.x);
    ud_diff[1] = (COORD_W+1)'(rdata.y) - (COORD_W+1)'(pa.y);
    ud_diff[2] = (COORD_W+1)'(rdata.z) - (COORD_W+1)'(pa.z);
  end

  // bend = 1 - dot, dot truncated toward zero from Q6.32
  always_comb begin
    tq = (dot >= 0) ? (dot >>> FRAC_W) : -((-dot) >>> FRAC_W);
    bv = DW'(BEND_ONE) - tq;
    if (bv < 0) begin
      bend = '0;
    end else if (bv > DW'(BEND_MAX)) begin
      bend = THR_W'(BEND_MAX);
    end else begin
      bend = bv[THR_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && point.end_of_stroke) state_next = S_BEGIN;
      end
      S_BEGIN: state_next = (count < CW'(MIN_POLY)) ? S_EM_NEXT : S_SM_START;
      S_SM_START: begin
        if (pass_left != '0) begin
          state_next = S_SM_CAP0;
        end else if (thk_phase) begin
          state_next = S_CP_START;
        end
      end
      S_SM_CAP0: state_next = S_SM_CAP1;
      S_SM_CAP1: state_next = S_SM_RDN;
      S_SM_RDN:  state_next = S_SM_CAPN;
      S_SM_CAPN: state_next = thk_phase ? S_SM_WR : S_SM_DIV;
      S_SM_DIV: begin
        if (d3_done) state_next = S_SM_WR;
      end
      S_SM_WR:    state_next = last_step ? S_SM_START : S_SM_RDN;
      S_CP_START: state_next = S_CP_CAPA;
      S_CP_CAPA:  state_next = S_CP_NEXT;
      S_CP_NEXT: begin
        if (scan_end) begin
          state_next = found ? S_CP_START : S_EM_NEXT;
        end else if (!cur_removed) begin
          state_next = S_CP_CAPB;
        end
      end
      S_CP_CAPB: state_next = S_CP_UD;
      S_CP_UD: begin
        if (ud_done) state_next = have_u ? S_CP_MUL : S_CP_ADV;
      end
      S_CP_MUL: state_next = S_CP_SUM;
      S_CP_SUM: state_next = S_CP_CMP;
      S_CP_CMP: state_next = S_CP_ADV;
      S_CP_ADV: state_next = S_CP_NEXT;
      S_EM_NEXT: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end else if (!cur_removed) begin
          state_next = S_EM_OUT;
        end
      end
      S_EM_OUT: begin
        if (out_free) state_next = S_EM_NEXT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = idx[AW-1:0];
    wdata    = cur;
    raddr    = idx[AW-1:0];
    ud_start = 1'b0;
    d3_start = 1'b0;
    case (state)
      S_IDLE: begin
        we      = accept && room;
        waddr   = count[AW-1:0];
        wdata.x = point.pos_x;
        wdata.y = point.pos_y;
        wdata.z = point.pos_z;
        wdata.w = point.width_in;
      end
      S_SM_START: raddr = '0;
      S_SM_CAP0:  raddr = AW'(1);
      S_SM_RDN:   raddr = idx[AW-1:0] + AW'(1);
      S_SM_CAPN:  d3_start = !thk_phase;
      S_SM_WR: begin
        we = 1'b1;
        if (thk_phase) begin
          wdata.w = wsum[THK_W:1];
        end else begin
          wdata.x = d3_q[0];
          wdata.y = d3_q[1];
          wdata.z = d3_q[2];
        end
      end
      S_CP_START: raddr = '0;
      S_CP_CAPB:  ud_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      mask         <= '0;
      pos_passes   <= POS_PASSES_RST;
      thk_passes   <= THK_PASSES_RST;
      bend_thr     <= BEND_THR_RST;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POS_PASSES: pos_passes <= cfg_data[PASS_W-1:0];
          CFG_THK_PASSES: thk_passes <= cfg_data[PASS_W-1:0];
          CFG_BEND_THR:   bend_thr   <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (room) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == S_CP_NEXT && scan_end && found) begin
        mask[best] <= 1'b1;
      end
      if (state == S_EM_NEXT && scan_end) begin
        count <= '0;
        ovf   <= 1'b0;
        mask  <= '0;
      end
      if (state == S_EM_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_BEGIN: begin
        pass_left <= pos_passes;
        thk_phase <= 1'b0;
        idx       <= '0;
      end
      S_SM_START: begin
        if (pass_left != '0) begin
          idx <= CW'(1);
        end else if (!thk_phase) begin
          thk_phase <= 1'b1;
          pass_left <= thk_passes;
        end
      end
      S_SM_CAP0: prev <= rdata;
      S_SM_CAP1: cur  <= rdata;
      S_SM_CAPN: nxt  <= rdata;
      S_SM_WR: begin
        prev <= wdata;
        cur  <= nxt;
        if (last_step) begin
          pass_left <= pass_left - 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_CP_START: begin
        found  <= 1'b0;
        have_u <= 1'b0;
        minb   <= bend_thr;
        idx    <= CW'(1);
      end
      S_CP_CAPA: begin
        pa       <= rdata;
        prev_idx <= '0;
      end
      S_CP_NEXT: begin
        if (scan_end) begin
          idx <= '0;
        end else if (cur_removed) begin
          idx <= idx + 1'b1;
        end
      end
      S_CP_CAPB: pb <= rdata;
      S_CP_UD: begin
        if (ud_done) begin
          u_cur <= ud_u;
        end
      end
      S_CP_MUL: begin
        for (int k = 0; k < 3; k++) begin
          prod[k] <= u_prev[k] * u_cur[k];
        end
      end
      S_CP_SUM: dot <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
      S_CP_CMP: begin
        if (bend < minb) begin
          minb  <= bend;
          best  <= prev_idx;
          found <= 1'b1;
        end
      end
      S_CP_ADV: begin
        u_prev   <= u_cur;
        have_u   <= 1'b1;
        pa       <= pb;
        prev_idx <= idx[AW-1:0];
        idx      <= idx + 1'b1;
      end
      S_EM_NEXT: begin
        if (!scan_end && cur_removed) begin
          idx <= idx + 1'b1;
        end
      end
      S_EM_OUT: begin
        if (out_free) begin
          result.out_x       <= rdata.x;
          result.out_y       <= rdata.y;
          result.out_z       <= rdata.z;
          result.width_out   <= rdata.w;
          result.final_point <= idx == count - CW'(1);
          result.overflowed  <= ovf;
          idx                <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  pss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pss_div3 u_div3 (
    .clk   (clk),
    .rst   (rst),
    .start (d3_start),
    .sum   (d3_sum),
    .done  (d3_done),
    .q     (d3_q)
  );

  pss_udir u_udir (
    .clk   (clk),
    .rst   (rst),
    .start (ud_start),
    .diff  (ud_diff),
    .done  (ud_done),
    .u     (ud_u)
  );

endmodule

### rtl/pss_check.sv
// Port-level checks for the polyline smoothing and simplification block, bound to
// the top level. Depends on pss_pkg.
module pss_check
  import pss_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    point_valid,
  input logic    point_stall,
  input point_t  point,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && point.end_of_stroke |=> point_stall)
    else $error("end of stroke did not start processing");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(point_stall))
    else $error("result appeared while idle");

  a_busy_until_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.final_point |=> point_stall)
    else $error("stroke ended before its final point");

endmodule

bind polyline_smooth_and_simplify pss_check u_pss_check (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_stall  (point_stall),
  .point        (point),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
